/* hdl/mfrb_pkg.sv */
`default_nettype none

package mfrb_pkg;

   localparam int DEF_MAX_CAPACITY = 1024;
   localparam int DEF_MAX_CHANNELS = 8;

   localparam int DATA_W      = 32;
   localparam int CH_OUT_W    = 3;
   localparam int MOVED_W     = 16;
   localparam int PEND_W      = 10;
   localparam int DROP_W      = 32;
   localparam int CCOUNT_W    = 4;
   localparam int CAP_CFG_W   = 11;
   localparam int MAXF_W      = 4;
   localparam int APB_DATA_W  = 32;
   localparam int APB_ADDR_W  = 4;

   localparam logic [MAXF_W-1:0] READ_FRAMES_MAX = 4'd8;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_READ  = 1'b1;

   localparam logic [1:0] REG_ENABLE   = 2'd0;
   localparam logic [1:0] REG_CHANNELS = 2'd1;
   localparam logic [1:0] REG_CAPACITY = 2'd2;

   typedef struct packed {
      logic                kind;
      logic [DATA_W-1:0]   sample;
      logic                end_of_batch;
      logic [MAXF_W-1:0]   max_frames;
   } req_payload_type;

   typedef struct packed {
      logic [DATA_W-1:0]   sample_out;
      logic [CH_OUT_W-1:0] channel;
      logic                sample_valid;
      logic                last;
      logic [MOVED_W-1:0]  frames_moved;
      logic [PEND_W-1:0]   pending_frames;
      logic [DROP_W-1:0]   dropped_frames;
   } rsp_payload_type;

endpackage

`default_nettype wire

/* hdl/mfrb_if.sv */
`default_nettype none

interface mfrb_req_if import mfrb_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface mfrb_rsp_if import mfrb_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* hdl/multichannel_frame_ring_buffer.sv */
// Frame ring buffer for interleaved multichannel 32-bit samples. Write transactions
// carry one sample each, taken one per cycle unless a read run or output stall holds
// them; a frame is committed at its last channel, or dropped whole if the ring (one
// slot kept empty) is full at its first sample. A write with end_of_batch returns one
// report transaction. A read returns channel_count * min(max_frames, 8, stored) sample
// transactions, one per cycle unless the output stalls, limited by the single registered
// read port of the sample memory; the next request is taken once that run has left the
// output register. An empty or disabled read returns one transaction with sample_valid
// low. Writes to registers 0-2 clear the ring indices; enable high clears the drop count.
`default_nettype none

module multichannel_frame_ring_buffer import mfrb_pkg::*; #(
   parameter int MAX_CAPACITY = DEF_MAX_CAPACITY,
   parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   mfrb_req_if.sink                   req_bus,
   mfrb_rsp_if.source                 rsp_bus,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [APB_ADDR_W-1:0] paddr,
   input  wire logic [APB_DATA_W-1:0] pwdata,
   output logic      [APB_DATA_W-1:0] prdata,
   output logic                       pready
);

   localparam int SLOT_W    = $clog2(MAX_CAPACITY);
   localparam int CAP_W     = $clog2(MAX_CAPACITY + 1);
   localparam int CH_W      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int ADDR_W    = SLOT_W + CH_W;
   localparam int MEM_DEPTH = MAX_CAPACITY * (2 ** CH_W);
   localparam int CMP_W     = (SLOT_W > MAXF_W) ? SLOT_W : MAXF_W;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_READ = 1'b1;

   logic [DATA_W-1:0] mem [MEM_DEPTH];
   logic [DATA_W-1:0] mem_q_ff;

   logic                 state_ff,     state_in;
   logic                 enable_ff,    enable_in;
   logic [CCOUNT_W-1:0]  chan_cfg_ff,  chan_cfg_in;
   logic [CAP_CFG_W-1:0] cap_cfg_ff,   cap_cfg_in;
   logic [SLOT_W-1:0]    wr_off_ff,    wr_off_in;
   logic [SLOT_W-1:0]    rd_off_ff,    rd_off_in;
   logic [SLOT_W-1:0]    fill_ff,      fill_in;
   logic [CH_W-1:0]      pos_ff,       pos_in;
   logic                 dropping_ff,  dropping_in;
   logic [MOVED_W-1:0]   batch_ff,     batch_in;
   logic [DROP_W-1:0]    drop_ff,      drop_in;
   logic [CH_W-1:0]      rd_ch_ff,     rd_ch_in;
   logic [MAXF_W-1:0]    rd_left_ff,   rd_left_in;
   logic [MAXF_W-1:0]    rd_take_ff,   rd_take_in;
   logic                 s1_vld_ff,    s1_vld_in;
   logic [CH_W-1:0]      s1_ch_ff;
   logic                 s1_last_ff;
   logic                 out_vld_ff,   out_vld_in;
   rsp_payload_type      out_ff,       out_in;

   logic [CH_W-1:0]      nch_m1;
   logic [CAP_W-1:0]     cap_m1;
   logic                 cfg_wr;
   logic [1:0]           cfg_idx;
   logic                 accept;
   logic                 s1_move;
   logic                 issue;
   logic                 rd_end_ch;
   logic                 rd_last;
   logic                 first;
   logic                 drop_now;
   logic                 mem_we;
   logic [MAXF_W-1:0]    take;
   rsp_payload_type      res;
   logic                 res_load;

   // used geometry
   always_comb begin
      if (chan_cfg_ff == '0) begin
         nch_m1 = '0;
      end else if (32'(chan_cfg_ff) > 32'(MAX_CHANNELS)) begin
         nch_m1 = CH_W'(MAX_CHANNELS - 1);
      end else begin
         nch_m1 = CH_W'(chan_cfg_ff - 1'b1);
      end
      if (cap_cfg_ff < CAP_CFG_W'(2)) begin
         cap_m1 = CAP_W'(1);
      end else if (32'(cap_cfg_ff) > 32'(MAX_CAPACITY)) begin
         cap_m1 = CAP_W'(MAX_CAPACITY - 1);
      end else begin
         cap_m1 = CAP_W'(cap_cfg_ff - 1'b1);
      end
   end

   assign cfg_wr  = psel && penable && pwrite;
   assign cfg_idx = paddr[3:2];
   assign pready  = 1'b1;

   always_comb begin
      case (cfg_idx)
         REG_ENABLE:   prdata = APB_DATA_W'(enable_ff);
         REG_CHANNELS: prdata = APB_DATA_W'(chan_cfg_ff);
         REG_CAPACITY: prdata = APB_DATA_W'(cap_cfg_ff);
         default:      prdata = '0;
      endcase
   end

   assign req_bus.ready = (state_ff == ST_IDLE) && !s1_vld_ff
                          && (!out_vld_ff || rsp_bus.ready);
   assign accept        = req_bus.valid && req_bus.ready;
   assign rsp_bus.valid   = out_vld_ff;
   assign rsp_bus.payload = out_ff;

   assign s1_move   = s1_vld_ff && (!out_vld_ff || rsp_bus.ready);
   assign issue     = (state_ff == ST_READ) && (!s1_vld_ff || s1_move);
   assign rd_end_ch = (rd_ch_ff == nch_m1);
   assign rd_last   = rd_end_ch && (rd_left_ff == MAXF_W'(1));

   always_comb begin
      state_in    = state_ff;
      enable_in   = enable_ff;
      chan_cfg_in = chan_cfg_ff;
      cap_cfg_in  = cap_cfg_ff;
      wr_off_in   = wr_off_ff;
      rd_off_in   = rd_off_ff;
      fill_in     = fill_ff;
      pos_in      = pos_ff;
      dropping_in = dropping_ff;
      batch_in    = batch_ff;
      drop_in     = drop_ff;
      rd_ch_in    = rd_ch_ff;
      rd_left_in  = rd_left_ff;
      rd_take_in  = rd_take_ff;
      s1_vld_in   = s1_vld_ff;
      out_vld_in  = out_vld_ff;
      out_in      = out_ff;
      first       = 1'b0;
      drop_now    = 1'b0;
      mem_we      = 1'b0;
      take        = '0;
      res         = '0;
      res_load    = 1'b0;

      if (out_vld_ff && rsp_bus.ready) begin
         out_vld_in = 1'b0;
      end
      if (s1_move) begin
         s1_vld_in = 1'b0;
      end

      if (cfg_wr) begin
         case (cfg_idx)
            REG_ENABLE: begin
               enable_in = pwdata[0];
               if (pwdata[0]) begin
                  drop_in = '0;
               end
            end
            REG_CHANNELS: chan_cfg_in = pwdata[CCOUNT_W-1:0];
            REG_CAPACITY: cap_cfg_in  = pwdata[CAP_CFG_W-1:0];
            default: ;
         endcase
         if (cfg_idx inside {REG_ENABLE, REG_CHANNELS, REG_CAPACITY}) begin
            wr_off_in   = '0;
            rd_off_in   = '0;
            fill_in     = '0;
            pos_in      = '0;
            dropping_in = 1'b0;
            batch_in    = '0;
         end
      end

      if (accept) begin
         if (req_bus.payload.kind == KIND_WRITE) begin
            if (enable_ff) begin
               first    = (pos_ff == '0);
               drop_now = first ? (CAP_W'(fill_ff) >= cap_m1) : dropping_ff;
               if (first && drop_now && drop_ff != '1) begin
                  drop_in = drop_ff + 1'b1;
               end
               mem_we = !drop_now;
               if (pos_ff == nch_m1) begin
                  pos_in      = '0;
                  dropping_in = 1'b0;
                  if (!drop_now) begin
                     wr_off_in = (CAP_W'(wr_off_ff) >= cap_m1) ? '0 : wr_off_ff + 1'b1;
                     fill_in   = fill_ff + 1'b1;
                     if (batch_ff != '1) begin
                        batch_in = batch_ff + 1'b1;
                     end
                  end
               end else begin
                  pos_in      = pos_ff + 1'b1;
                  dropping_in = drop_now;
               end
            end
            if (req_bus.payload.end_of_batch) begin
               res_load           = 1'b1;
               res.last           = 1'b1;
               res.frames_moved   = batch_in;
               res.pending_frames = PEND_W'(fill_in);
               res.dropped_frames = drop_in;
               batch_in           = '0;
            end
         end else begin
            take = (req_bus.payload.max_frames > READ_FRAMES_MAX) ? READ_FRAMES_MAX
                                                                  : req_bus.payload.max_frames;
            if (CMP_W'(fill_ff) < CMP_W'(take)) begin
               take = MAXF_W'(fill_ff);
            end
            if (!enable_ff || take == '0) begin
               res_load           = 1'b1;
               res.last           = 1'b1;
               res.pending_frames = PEND_W'(fill_ff);
               res.dropped_frames = drop_ff;
            end else begin
               fill_in    = fill_ff - SLOT_W'(take);
               rd_take_in = take;
               rd_left_in = take;
               rd_ch_in   = '0;
               state_in   = ST_READ;
            end
         end
      end

      if (issue) begin
         s1_vld_in = 1'b1;
         if (rd_end_ch) begin
            rd_ch_in   = '0;
            rd_off_in  = (CAP_W'(rd_off_ff) >= cap_m1) ? '0 : rd_off_ff + 1'b1;
            rd_left_in = rd_left_ff - 1'b1;
            if (rd_last) begin
               state_in = ST_IDLE;
            end
         end else begin
            rd_ch_in = rd_ch_ff + 1'b1;
         end
      end

      if (s1_move) begin
         out_vld_in            = 1'b1;
         out_in.sample_out     = mem_q_ff;
         out_in.channel        = CH_OUT_W'(s1_ch_ff);
         out_in.sample_valid   = 1'b1;
         out_in.last           = s1_last_ff;
         out_in.frames_moved   = MOVED_W'(rd_take_ff);
         out_in.pending_frames = PEND_W'(fill_ff);
         out_in.dropped_frames = drop_ff;
      end else if (res_load) begin
         out_vld_in = 1'b1;
         out_in     = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         enable_ff   <= 1'b0;
         chan_cfg_ff <= CCOUNT_W'(1);
         cap_cfg_ff  <= CAP_CFG_W'(2);
         wr_off_ff   <= '0;
         rd_off_ff   <= '0;
         fill_ff     <= '0;
         pos_ff      <= '0;
         dropping_ff <= 1'b0;
         batch_ff    <= '0;
         drop_ff     <= '0;
         rd_ch_ff    <= '0;
         rd_left_ff  <= '0;
         rd_take_ff  <= '0;
         s1_vld_ff   <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         enable_ff   <= enable_in;
         chan_cfg_ff <= chan_cfg_in;
         cap_cfg_ff  <= cap_cfg_in;
         wr_off_ff   <= wr_off_in;
         rd_off_ff   <= rd_off_in;
         fill_ff     <= fill_in;
         pos_ff      <= pos_in;
         dropping_ff <= dropping_in;
         batch_ff    <= batch_in;
         drop_ff     <= drop_in;
         rd_ch_ff    <= rd_ch_in;
         rd_left_ff  <= rd_left_in;
         rd_take_ff  <= rd_take_in;
         s1_vld_ff   <= s1_vld_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      if (issue) begin
         s1_ch_ff   <= rd_ch_ff;
         s1_last_ff <= rd_last;
      end
   end

   // sample memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[ADDR_W'({wr_off_ff, pos_ff})] <= req_bus.payload.sample;
      end
      if (issue) begin
         mem_q_ff <= mem[ADDR_W'({rd_off_ff, rd_ch_ff})];
      end
   end

endmodule

`default_nettype wire

/* tb/multichannel_frame_ring_buffer_checker.sv */
`timescale 1ns / 1ps

module multichannel_frame_ring_buffer_checker import mfrb_pkg::*; #(
   parameter int MAX_CAPACITY = DEF_MAX_CAPACITY,
   parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_payload_type       req_payload,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_payload_type       rsp_payload,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [APB_ADDR_W-1:0] paddr,
   input  logic [APB_DATA_W-1:0] pwdata,
   input  logic                  pready,
   output int                    mismatches,
   output int                    outstanding
);

   logic [DATA_W-1:0]    sample_mem [MAX_CAPACITY*MAX_CHANNELS];
   logic                 run_en;
   logic [CCOUNT_W-1:0]  chan_reg;
   logic [CAP_CFG_W-1:0] cap_reg;
   int unsigned          wr_slot;
   int unsigned          rd_slot;
   int unsigned          stored;
   int unsigned          pos_in_frame;
   logic                 dropping_frame;
   int unsigned          batch_frames;
   int unsigned          drops;
   int                   failures = 0;
   rsp_payload_type      expected_q [$];

   function automatic int unsigned frame_width();
      if (chan_reg < 1) return 1;
      if (chan_reg > MAX_CHANNELS) return MAX_CHANNELS;
      return chan_reg;
   endfunction

   function automatic int unsigned ring_slots();
      if (cap_reg < 2) return 2;
      if (cap_reg > MAX_CAPACITY) return MAX_CAPACITY;
      return cap_reg;
   endfunction

   function automatic void clear_ring();
      wr_slot = 0;
      rd_slot = 0;
      stored = 0;
      pos_in_frame = 0;
      dropping_frame = 1'b0;
      batch_frames = 0;
   endfunction

   function automatic void push_result(logic [DATA_W-1:0] word, int unsigned ch, logic valid,
                                       logic last_flag, int unsigned moved);
      rsp_payload_type r;
      r.sample_out     = word;
      r.channel        = CH_OUT_W'(ch);
      r.sample_valid   = valid;
      r.last           = last_flag;
      r.frames_moved   = MOVED_W'(moved);
      r.pending_frames = PEND_W'(stored);
      r.dropped_frames = DROP_W'(drops);
      expected_q.push_back(r);
   endfunction

   function automatic void write_register(logic [1:0] index, logic [APB_DATA_W-1:0] value);
      case (index)
         REG_ENABLE: begin
            run_en = value[0];
            clear_ring();
            if (value[0]) drops = 0;
         end
         REG_CHANNELS: begin
            chan_reg = value[CCOUNT_W-1:0];
            clear_ring();
         end
         REG_CAPACITY: begin
            cap_reg = value[CAP_CFG_W-1:0];
            clear_ring();
         end
         default: ;
      endcase
   endfunction

   function automatic void predict_item(req_payload_type item);
      int unsigned nch;
      int unsigned cap;
      int unsigned take;
      int unsigned moved;
      int unsigned f;
      int unsigned c;
      nch = frame_width();
      cap = ring_slots();
      if (item.kind == KIND_WRITE) begin
         if (run_en) begin
            if (pos_in_frame == 0) begin
               dropping_frame = (stored >= cap - 1);
               if (dropping_frame && drops != 32'hFFFF_FFFF) drops++;
            end
            if (!dropping_frame) sample_mem[wr_slot*MAX_CHANNELS + pos_in_frame] = item.sample;
            pos_in_frame++;
            if (pos_in_frame >= nch) begin
               pos_in_frame = 0;
               if (!dropping_frame) begin
                  wr_slot = (wr_slot + 1 >= cap) ? 0 : wr_slot + 1;
                  stored++;
                  if (batch_frames < 16'hFFFF) batch_frames++;
               end
               dropping_frame = 1'b0;
            end
         end
         if (item.end_of_batch) begin
            moved = batch_frames;
            batch_frames = 0;
            push_result('0, 0, 1'b0, 1'b1, moved);
         end
      end else begin
         take = item.max_frames;
         if (take > READ_FRAMES_MAX) take = READ_FRAMES_MAX;
         if (take > stored) take = stored;
         if (!run_en || take == 0) begin
            push_result('0, 0, 1'b0, 1'b1, 0);
         end else begin
            stored -= take;
            for (f = 0; f < take; f++) begin
               for (c = 0; c < nch; c++)
                  push_result(sample_mem[rd_slot*MAX_CHANNELS + c], c, 1'b1,
                              (f + 1 == take) && (c + 1 == nch), take);
               rd_slot = (rd_slot + 1 >= cap) ? 0 : rd_slot + 1;
            end
         end
      end
   endfunction

   always @(posedge clock) begin
      rsp_payload_type want;
      rsp_payload_type got;
      if (reset) begin
         run_en = 1'b0;
         chan_reg = 1;
         cap_reg = 2;
         drops = 0;
         clear_ring();
         expected_q.delete();
      end else begin
         if (psel && penable && pwrite && pready) write_register(paddr[APB_ADDR_W-1:2], pwdata);
         if (req_valid && req_ready) predict_item(req_payload);
         if (rsp_valid && rsp_ready) begin
            got = rsp_payload;
            if (expected_q.size() == 0) begin
               if (failures < 10)
                  $display("%0t: unexpected result sample_out=%h channel=%0d valid=%0b last=%0b",
                           $realtime, got.sample_out, got.channel, got.sample_valid, got.last);
               failures++;
            end else begin
               want = expected_q.pop_front();
               if (got.sample_out !== want.sample_out || got.channel !== want.channel ||
                   got.sample_valid !== want.sample_valid || got.last !== want.last ||
                   got.frames_moved !== want.frames_moved ||
                   got.pending_frames !== want.pending_frames ||
                   got.dropped_frames !== want.dropped_frames) begin
                  if (failures < 10) begin
                     $display("%0t: mismatch expected sample_out=%h channel=%0d valid=%0b last=%0b",
                              $realtime, want.sample_out, want.channel, want.sample_valid,
                              want.last);
                     $display("   moved=%0d pending=%0d dropped=%0d",
                              want.frames_moved, want.pending_frames, want.dropped_frames);
                     $display("   actual sample_out=%h channel=%0d valid=%0b last=%0b",
                              got.sample_out, got.channel, got.sample_valid, got.last);
                     $display("   moved=%0d pending=%0d dropped=%0d",
                              got.frames_moved, got.pending_frames, got.dropped_frames);
                  end
                  failures++;
               end
            end
         end
      end
      mismatches <= failures;
      outstanding <= expected_q.size();
   end

endmodule

/* tb/multichannel_frame_ring_buffer_tb.sv */
`timescale 1ns / 1ps

module multichannel_frame_ring_buffer_tb;
   import mfrb_pkg::*;

   localparam int         CLOCK_HALF  = 5;
   localparam int         STALL_LIMIT = 5000;
   localparam logic [1:0] REG_SPARE   = 2'd3;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [APB_ADDR_W-1:0] paddr;
   logic [APB_DATA_W-1:0] pwdata;
   logic [APB_DATA_W-1:0] prdata;
   logic                  pready;
   int                    mismatches;
   int                    outstanding;
   int                    send_idle_pct = 0;
   int                    recv_stall_pct = 0;
   int                    quiet_cycles = 0;
   int unsigned           cur_width = 1;
   int unsigned           items_sent = 0;

   mfrb_req_if req_bus ();
   mfrb_rsp_if rsp_bus ();

   multichannel_frame_ring_buffer u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   multichannel_frame_ring_buffer_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_bus.valid),
      .req_ready   (req_bus.ready),
      .req_payload (req_bus.payload),
      .rsp_valid   (rsp_bus.valid),
      .rsp_ready   (rsp_bus.ready),
      .rsp_payload (rsp_bus.payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .pready      (pready),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (psel && penable))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("multichannel_frame_ring_buffer regression: fail");
         $finish;
      end
   end

   task automatic send_item(logic kind, logic [DATA_W-1:0] word, logic eob,
                            logic [MAXF_W-1:0] maxf);
      req_payload_type item;
      item.kind         = kind;
      item.sample       = word;
      item.end_of_batch = eob;
      item.max_frames   = maxf;
      if ($urandom_range(99, 0) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99, 0) < send_idle_pct) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.payload <= item;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      items_sent++;
   endtask

   task automatic write_word(logic [DATA_W-1:0] word, logic eob);
      send_item(KIND_WRITE, word, eob, MAXF_W'($urandom_range(15, 0)));
   endtask

   task automatic read_frames(int unsigned count);
      send_item(KIND_READ, $urandom, 1'($urandom_range(1, 0)), MAXF_W'(count));
   endtask

   // whole frames, with an occasional stray batch end inside them
   task automatic write_batch(int unsigned frames);
      int unsigned total;
      total = frames * cur_width;
      for (int unsigned n = 1; n <= total; n++)
         write_word($urandom, (n == total) || ($urandom_range(19, 0) == 0));
   endtask

   // wait until every transaction expected so far has come back
   task automatic settle(int cycles);
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (cycles) @(posedge clock);
   endtask

   task automatic reg_write(logic [1:0] index, logic [APB_DATA_W-1:0] value);
      settle(8);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= APB_ADDR_W'({index, 2'b00});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic configure(logic [CCOUNT_W-1:0] chans, logic [CAP_CFG_W-1:0] slots);
      reg_write(REG_CHANNELS, APB_DATA_W'(chans));
      reg_write(REG_CAPACITY, APB_DATA_W'(slots));
      if (chans == 0)
         cur_width = 1;
      else if (chans > DEF_MAX_CHANNELS)
         cur_width = DEF_MAX_CHANNELS;
      else
         cur_width = chans;
   endtask

   task automatic run_phase(idle_mode_type mode, int unsigned count);
      int unsigned target;
      int unsigned pick;
      target = items_sent + count;
      case (mode)
         IDLE_NONE: begin
            send_idle_pct = 0;
            recv_stall_pct <= 0;
         end
         IDLE_SENDER: begin
            send_idle_pct = 74;
            recv_stall_pct <= 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct = 0;
            recv_stall_pct <= 74;
         end
         IDLE_BOTH: begin
            send_idle_pct = 31;
            recv_stall_pct <= 31;
         end
         default: ;
      endcase
      while (items_sent < target) begin
         pick = $urandom_range(99, 0);
         if (pick < 55)
            write_batch($urandom_range(3, 1));
         else if (pick < 80)
            read_frames($urandom_range(8, 1));
         else if (pick < 90)
            read_frames($urandom_range(15, 0));
         else
            write_word($urandom, 1'($urandom_range(1, 0)));
      end
   endtask

   initial begin
      req_bus.valid   <= 1'b0;
      req_bus.payload <= '0;
      psel            <= 1'b0;
      penable         <= 1'b0;
      pwrite          <= 1'b0;
      paddr           <= '0;
      pwdata          <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // disabled after reset
      write_word(32'h0000_0000, 1'b1);
      read_frames(8);
      write_word(32'hFFFF_FFFF, 1'b0);

      reg_write(REG_ENABLE, 1);
      configure(2, 2);
      write_word(32'h0000_0000, 1'b0);
      write_word(32'hFFFF_FFFF, 1'b1);
      // ring full: whole frame dropped
      write_word(32'hFFFF_FFFF, 1'b0);
      write_word(32'h0000_0000, 1'b1);
      read_frames(0);
      read_frames(15);
      read_frames(1);
      // batch ends inside a frame
      write_word(32'hA5A5_A5A5, 1'b1);
      write_word(32'h5A5A_5A5A, 1'b1);
      read_frames(8);

      configure(1, 2);
      run_phase(IDLE_NONE, 34);
      configure(8, 5);
      run_phase(IDLE_SENDER, 34);
      reg_write(REG_ENABLE, 1);
      configure(3, 11'd2047);
      run_phase(IDLE_RECEIVER, 34);
      configure(0, 3);
      reg_write(REG_SPARE, $urandom);
      reg_write(REG_ENABLE, 1);
      run_phase(IDLE_BOTH, 17);
      settle(0);
      run_phase(IDLE_BOTH, 17);
      configure(15, 0);
      run_phase(IDLE_NONE, 34);
      configure(5, 9);
      run_phase(IDLE_SENDER, 30);
      reg_write(REG_ENABLE, 0);
      run_phase(IDLE_RECEIVER, 16);
      reg_write(REG_ENABLE, 1);
      configure(4, 7);
      run_phase(IDLE_BOTH, 34);

      settle(20);
      if (mismatches == 0 && outstanding == 0)
         $display("multichannel_frame_ring_buffer regression: pass");
      else
         $display("multichannel_frame_ring_buffer regression: fail");
      $finish;
   end

endmodule
